@@ hdl/nsm_pkg.sv @@
// nsm_pkg: shared types, constants and the sine table function for the
// NCO sample mixer. No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package nsm_pkg;

  // Fixed field widths
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned MAG_W       = SAMPLE_BITS - 1;
  localparam int unsigned CFG_W       = 32;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned MODE_W      = 2;

  // Defaults for the top-level parameters
  localparam int unsigned PHASE_BITS_DEF      = 32;
  localparam int unsigned TABLE_ADDR_BITS_DEF = 10;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_PHASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIX_MODE    = 2'd2;

  // Mix modes (the unused code behaves as bypass)
  localparam logic [MODE_W-1:0] MODE_BYPASS  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REAL    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMPLEX = 2'd2;

  // pi/2 and 1.0 in Q30
  localparam longint unsigned HALFPI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30    = 64'd1073741824;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_re;
    logic signed [SAMPLE_BITS-1:0] sample_im;
    logic                          record_start;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_re;
    logic signed [SAMPLE_BITS-1:0] out_im;
  } out_item_t;

  // Quarter-wave entry k of a table with 2^tbits entries: sine at the
  // middle of the k-th slot, Taylor series in Q30, scaled to full scale.
  // Evaluated at elaboration only.
  function automatic logic [MAG_W-1:0] quarter_sine(int unsigned k, int unsigned tbits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned mag;
    longint unsigned amp;
    longint          acc;
    amp  = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
    x    = (HALFPI_Q30 * (64'd2 * longint'(k) + 64'd1)) >> (tbits + 1);
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = (term * x2) >> 30;
      // divide by (2n)(2n+1)
      case (n)
        1: begin
          term = term / 64'd6;
        end
        2: begin
          term = term / 64'd20;
        end
        3: begin
          term = term / 64'd42;
        end
        4: begin
          term = term / 64'd72;
        end
        5: begin
          term = term / 64'd110;
        end
        6: begin
          term = term / 64'd156;
        end
        default: begin
          term = term / 64'd210;
        end
      endcase
      if (n[0]) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (longint'(ONE_Q30) < acc) begin
      acc = longint'(ONE_Q30);
    end
    mag = (longint'(acc) * amp + (64'd1 << 29)) >> 30;
    if (mag > amp) begin
      mag = amp;
    end
    return mag[MAG_W-1:0];
  endfunction

endpackage

@@ hdl/nsm_phase.sv @@
// nsm_phase: phase accumulator of the NCO and the phase register of the
// first pipeline stage. Depends on nsm_pkg.
`timescale 1ns / 1ps

module nsm_phase #(
  parameter int unsigned PHASE_BITS = nsm_pkg::PHASE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [nsm_pkg::CFG_W-1:0]   phase_step,
  input  logic [nsm_pkg::CFG_W-1:0]   start_phase,
  input  logic                        accept,
  input  logic                        load,
  input  logic                        record_start,
  output logic [PHASE_BITS-1:0]       phase
);
  import nsm_pkg::*;

  logic [PHASE_BITS-1:0] phase_acc;
  logic [PHASE_BITS-1:0] step_al;
  logic [PHASE_BITS-1:0] start_al;
  logic [PHASE_BITS-1:0] phase_next;

  // Align the 32-bit registers to the accumulator width
  if (PHASE_BITS >= CFG_W) begin : g_up
    assign step_al  = PHASE_BITS'(phase_step) << (PHASE_BITS - CFG_W);
    assign start_al = PHASE_BITS'(start_phase) << (PHASE_BITS - CFG_W);
  end else begin : g_dn
    assign step_al  = PHASE_BITS'(phase_step >> (CFG_W - PHASE_BITS));
    assign start_al = PHASE_BITS'(start_phase >> (CFG_W - PHASE_BITS));
  end

  assign phase_next = record_start ? start_al : phase_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
    end else if (accept) begin
      phase_acc <= phase_next - step_al;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      phase <= phase_next;
    end
  end

endmodule

@@ hdl/nsm_sincos.sv @@
// nsm_sincos: quadrant decode and quarter-wave sine table with two
// registered read ports (sine and cosine). Depends on nsm_pkg.
`timescale 1ns / 1ps

module nsm_sincos #(
  parameter int unsigned TABLE_ADDR_BITS = nsm_pkg::TABLE_ADDR_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [TABLE_ADDR_BITS+1:0]  phase_top,
  output logic [nsm_pkg::MAG_W-1:0]   sin_mag,
  output logic [nsm_pkg::MAG_W-1:0]   cos_mag,
  output logic                        sin_neg,
  output logic                        cos_neg
);
  import nsm_pkg::*;

  localparam int unsigned DEPTH = 1 << TABLE_ADDR_BITS;

  logic [MAG_W-1:0]           rom [DEPTH];
  logic [1:0]                 quad;
  logic [1:0]                 quad_c;
  logic [TABLE_ADDR_BITS-1:0] k;
  logic [TABLE_ADDR_BITS-1:0] sin_addr;
  logic [TABLE_ADDR_BITS-1:0] cos_addr;

  for (genvar i = 0; i < DEPTH; i++) begin : g_rom
    assign rom[i] = quarter_sine(i, TABLE_ADDR_BITS);
  end

  assign quad   = phase_top[TABLE_ADDR_BITS+1:TABLE_ADDR_BITS];
  assign k      = phase_top[TABLE_ADDR_BITS-1:0];
  // cosine is one quadrant ahead
  assign quad_c = quad + 2'd1;

  assign sin_addr = quad[0]   ? ~k : k;
  assign cos_addr = quad_c[0] ? ~k : k;

  always_ff @(posedge clk) begin
    if (en) begin
      sin_mag <= rom[sin_addr];
      cos_mag <= rom[cos_addr];
      sin_neg <= quad[1];
      cos_neg <= quad_c[1];
    end
  end

endmodule

@@ hdl/nsm_mixer.sv @@
// nsm_mixer: product stage and round/saturate output stage of the mixer.
// Depends on nsm_pkg.
`timescale 1ns / 1ps

module nsm_mixer (
  input  logic                               clk,
  input  logic                               en_prod,
  input  logic                               en_out,
  input  logic [nsm_pkg::MODE_W-1:0]         mix_mode,
  input  logic [nsm_pkg::MAG_W-1:0]          sin_mag,
  input  logic [nsm_pkg::MAG_W-1:0]          cos_mag,
  input  logic                               sin_neg,
  input  logic                               cos_neg,
  input  logic signed [nsm_pkg::SAMPLE_BITS-1:0] re,
  input  logic signed [nsm_pkg::SAMPLE_BITS-1:0] im,
  output nsm_pkg::out_item_t                 out_item
);
  import nsm_pkg::*;

  localparam int unsigned PW = 2 * SAMPLE_BITS;
  localparam int unsigned SW = PW + 1;
  localparam int unsigned QW = SAMPLE_BITS + 2;
  localparam logic signed [QW-1:0] SAT_HI = QW'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [QW-1:0] SAT_LO = -SAT_HI - QW'(1);
  localparam logic signed [SW-1:0] HALF   = SW'(1 << (SAMPLE_BITS - 2));

  logic signed [SAMPLE_BITS-1:0] s_val;
  logic signed [SAMPLE_BITS-1:0] c_val;
  logic signed [PW-1:0] p_rc, p_is, p_rs, p_ic;
  logic signed [SAMPLE_BITS-1:0] re_d, im_d;
  logic signed [SW-1:0] sum_re, sum_im;
  logic signed [SW-1:0] sh_re, sh_im;
  logic signed [QW-1:0] q_re, q_im;
  logic signed [SAMPLE_BITS-1:0] sat_re, sat_im;
  logic mode_real, mode_cplx;

  assign s_val = sin_neg ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
  assign c_val = cos_neg ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});

  always_ff @(posedge clk) begin
    if (en_prod) begin
      p_rc <= re * c_val;
      p_is <= im * s_val;
      p_rs <= re * s_val;
      p_ic <= im * c_val;
      re_d <= re;
      im_d <= im;
    end
  end

  assign mode_real = (mix_mode == MODE_REAL);
  assign mode_cplx = (mix_mode == MODE_COMPLEX);

  // real mode drops the cross terms
  assign sum_re = SW'(p_rc) - (mode_cplx ? SW'(p_is) : '0);
  assign sum_im = SW'(p_ic) + (mode_cplx ? SW'(p_rs) : '0);

  // round half up, floor shift
  assign sh_re = (sum_re + HALF) >>> (SAMPLE_BITS - 1);
  assign sh_im = (sum_im + HALF) >>> (SAMPLE_BITS - 1);
  assign q_re  = sh_re[QW-1:0];
  assign q_im  = sh_im[QW-1:0];

  assign sat_re = (q_re > SAT_HI) ? SAT_HI[SAMPLE_BITS-1:0] :
                  (q_re < SAT_LO) ? SAT_LO[SAMPLE_BITS-1:0] : q_re[SAMPLE_BITS-1:0];
  assign sat_im = (q_im > SAT_HI) ? SAT_HI[SAMPLE_BITS-1:0] :
                  (q_im < SAT_LO) ? SAT_LO[SAMPLE_BITS-1:0] : q_im[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (en_out) begin
      if (mode_real || mode_cplx) begin
        out_item.out_re <= sat_re;
        out_item.out_im <= sat_im;
      end else begin
        out_item.out_re <= re_d;
        out_item.out_im <= im_d;
      end
    end
  end

endmodule

@@ hdl/nco_sample_mixer.sv @@
// nco_sample_mixer: top level of the NCO and mixer for digitizer records.
// Depends on nsm_pkg, nsm_phase, nsm_sincos and nsm_mixer.
`timescale 1ns / 1ps

// Usage
//  - Input channel (in_valid/in_ready/in_item): one sample pair per item;
//    record_start marks the first sample of a record and reloads the phase
//    from start_phase. Each later item steps the phase down by phase_step.
//  - Output channel (out_valid/out_ready/out_item): one result per item,
//    in input order.
//  - Config port (cfg_wr_en/cfg_index/cfg_data): single-cycle writes to
//    phase_step, start_phase, mix_mode; write only while the block is idle.
//    Index 3 is ignored.
//  - Data path: each item passes four registers (phase, sine table read,
//    products, round/saturate output register).
//  - Throughput: one item per clock while out_ready is high; the 4-stage
//    pipeline advances stage by stage, so bubbles close up and new items are
//    taken while a finished result waits at the output register.
//  - Reset (rst, synchronous): clears the configuration registers, the phase
//    accumulator and the pipeline valid bits; no output is pending afterwards.
//  - When out_ready is low the output holds; the stages behind it fill and
//    in_ready drops once all four hold items.

module nco_sample_mixer #(
  parameter int unsigned PHASE_BITS      = nsm_pkg::PHASE_BITS_DEF,
  parameter int unsigned TABLE_ADDR_BITS = nsm_pkg::TABLE_ADDR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  nsm_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output nsm_pkg::out_item_t            out_item,
  input  logic                          cfg_wr_en,
  input  logic [nsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nsm_pkg::CFG_W-1:0]     cfg_data
);
  import nsm_pkg::*;

  // Configuration registers
  logic [CFG_W-1:0]  phase_step;
  logic [CFG_W-1:0]  start_phase;
  logic [MODE_W-1:0] mix_mode;

  // Pipeline valids and per-stage ready
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3, rdy4;
  logic accept;

  // Stage data
  logic [PHASE_BITS-1:0]         phase;
  logic signed [SAMPLE_BITS-1:0] re1, im1, re2, im2;
  logic [MAG_W-1:0]              sin_mag, cos_mag;
  logic                          sin_neg, cos_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step  <= '0;
      start_phase <= '0;
      mix_mode    <= MODE_BYPASS;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PHASE_STEP:  phase_step  <= cfg_data;
        REG_START_PHASE: start_phase <= cfg_data;
        REG_MIX_MODE:    mix_mode    <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or its successor moves on
  assign rdy4     = !out_valid || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;
  assign accept   = in_valid && rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) out_valid <= v3;
    end
  end

  // Stage 1: phase select and accumulator update
  nsm_phase #(
    .PHASE_BITS (PHASE_BITS)
  ) u_phase (
    .clk          (clk),
    .rst          (rst),
    .phase_step   (phase_step),
    .start_phase  (start_phase),
    .accept       (accept),
    .load         (rdy1),
    .record_start (in_item.record_start),
    .phase        (phase)
  );

  always_ff @(posedge clk) begin
    if (rdy1) begin
      re1 <= in_item.sample_re;
      im1 <= in_item.sample_im;
    end
    if (rdy2) begin
      re2 <= re1;
      im2 <= im1;
    end
  end

  // Stage 2: table lookup on the top phase bits
  nsm_sincos #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_sincos (
    .clk       (clk),
    .en        (rdy2),
    .phase_top (phase[PHASE_BITS-1 -: TABLE_ADDR_BITS+2]),
    .sin_mag   (sin_mag),
    .cos_mag   (cos_mag),
    .sin_neg   (sin_neg),
    .cos_neg   (cos_neg)
  );

  // Stages 3 and 4: products, then round/saturate into the output register
  nsm_mixer u_mixer (
    .clk      (clk),
    .en_prod  (rdy3),
    .en_out   (rdy4),
    .mix_mode (mix_mode),
    .sin_mag  (sin_mag),
    .cos_mag  (cos_mag),
    .sin_neg  (sin_neg),
    .cos_neg  (cos_neg),
    .re       (re2),
    .im       (im2),
    .out_item (out_item)
  );

endmodule

@@ test/tb.sv @@
// tb: self-checking bench for nco_sample_mixer (NCO plus bypass/real/complex mixer).
// Depends on nsm_pkg and the nco_sample_mixer RTL. A bit-true phase/sine/mix
// predictor in this file produces the expected result of every accepted item.
`timescale 1ns / 1ps

module tb;
  import nsm_pkg::*;

  // Bench knobs
  localparam int PIPE_LAT    = 3;       // accept edge to out_valid
  localparam int LIMIT       = 200000;  // watchdog, far above the slowest clean run
  localparam int TBITS       = 10;      // table address bits at the default build
  localparam int N_BATCH     = 10;
  localparam int BATCH_ITEMS = 180;

  // Mode code 3 has no name in the package; the block treats it as bypass
  localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
  // Register index 3 is decoded as nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned UNIT_Q30    = 64'd1073741824;
  localparam longint unsigned FULL_SCALE  = 64'd32767;
  localparam logic [31:0]     QUARTER     = 32'h4000_0000;
  localparam logic [TBITS-1:0] TLAST      = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_item_t         in_item   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_item;
  logic             cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  nco_sample_mixer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the register file and the phase accumulator
  logic [31:0]       step_cfg  = '0;
  logic [31:0]       start_cfg = '0;
  logic [MODE_W-1:0] mode_cfg  = MODE_BYPASS;
  logic [31:0]       nco_phase = '0;

  in_item_t  sample_q[$];     // items waiting for the driver
  out_item_t mix_expect_q[$]; // predicted mixer outputs, oldest first
  int n_pushed   = 0;
  int n_accepted = 0;
  int n_err      = 0;
  int idle_pct   = 30;        // per-cycle chance (percent) that a side idles
  int cycle_cnt  = 0;
  logic in_took  = 1'b0;      // item accepted at the last rising edge

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Magnitude of quarter-wave slot k: sine at the slot center, Q30 Taylor
  // series to the 15th power, rounded to full scale.
  function automatic int slot_sine(int unsigned k);
    longint unsigned ang;
    longint unsigned ang_sq;
    longint unsigned trm;
    longint unsigned mag;
    longint          sum;
    ang    = (HALF_PI_Q30 * (64'd2 * k + 64'd1)) >> (TBITS + 1);
    ang_sq = (ang * ang) >> 30;
    trm    = ang;
    sum    = longint'(ang);
    for (int n = 1; n <= 7; n++) begin
      trm = ((trm * ang_sq) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n[0]) begin
        sum = sum - longint'(trm);
      end else begin
        sum = sum + longint'(trm);
      end
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(UNIT_Q30)) sum = longint'(UNIT_Q30);
    mag = (unsigned'(sum) * FULL_SCALE + (64'd1 << 29)) >> 30;
    if (mag > FULL_SCALE) mag = FULL_SCALE;
    return int'(mag);
  endfunction

  // Signed sine of a 32-bit phase: top 2 bits pick the quadrant,
  // the next TBITS the slot (mirrored in odd quadrants).
  function automatic int sine_at(logic [31:0] p);
    logic [TBITS+1:0] top;
    logic [TBITS-1:0] idx;
    int v;
    top = p[31 -: TBITS + 2];
    idx = top[TBITS-1:0];
    if (top[TBITS]) idx = TLAST - idx;
    v = slot_sine(idx);
    return top[TBITS+1] ? -v : v;
  endfunction

  // Add half an LSB, floor-divide by 2^15, clip to Q1.15
  function automatic logic signed [SAMPLE_BITS-1:0] round_q15(longint acc);
    longint q;
    q = (acc + 64'sd16384) >>> 15;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[SAMPLE_BITS-1:0];
  endfunction

  // Expected result for one item; advances the shadow accumulator
  function automatic out_item_t predict_mix(in_item_t it);
    out_item_t r;
    logic [31:0] p;
    longint re;
    longint im;
    longint c;
    longint s;
    p         = it.record_start ? start_cfg : nco_phase;
    nco_phase = p - step_cfg;   // NCO runs down, in every mode
    re = it.sample_re;
    im = it.sample_im;
    c  = sine_at(p + QUARTER);
    s  = sine_at(p);
    case (mode_cfg)
      MODE_REAL: begin
        r.out_re = round_q15(re * c);
        r.out_im = round_q15(im * c);
      end
      MODE_COMPLEX: begin
        r.out_re = round_q15(re * c - im * s);
        r.out_im = round_q15(re * s + im * c);
      end
      default: begin
        // bypass and the unused code
        r.out_re = it.sample_re;
        r.out_im = it.sample_im;
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: launches items and toggles out_ready on the falling edge
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      // a new item only once the current one has gone in
      if (!in_valid || in_took) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_item  <= sample_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: predicts on input accepts, checks on output accepts
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        mix_expect_q.insert(mix_expect_q.size(), predict_mix(in_item));
        n_accepted++;
      end
      if (out_valid && out_ready) begin
        if (mix_expect_q.size() == 0) begin
          n_err++;
          if (n_err <= 10)
            $display("%0t: result with nothing pending: re=%0d im=%0d",
                     $realtime, out_item.out_re, out_item.out_im);
        end else begin
          want = mix_expect_q.pop_front();
          if (out_item.out_re !== want.out_re || out_item.out_im !== want.out_im) begin
            n_err++;
            if (n_err <= 10)
              $display("%0t: mismatch re exp %0d got %0d, im exp %0d got %0d",
                       $realtime, want.out_re, out_item.out_re,
                       want.out_im, out_item.out_im);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // One register write, launched on the falling edge; shadow follows
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_PHASE_STEP:  step_cfg  = val;
      REG_START_PHASE: start_cfg = val;
      REG_MIX_MODE:    mode_cfg  = val[MODE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_nco(logic [31:0] step, logic [31:0] start,
                             logic [MODE_W-1:0] mode);
    write_reg(REG_PHASE_STEP, step);
    write_reg(REG_START_PHASE, start);
    write_reg(REG_MIX_MODE, CFG_W'(mode));
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic push_item(int re, int im, bit rs);
    in_item_t it;
    it.sample_re    = re[SAMPLE_BITS-1:0];
    it.sample_im    = im[SAMPLE_BITS-1:0];
    it.record_start = rs;
    sample_q.insert(sample_q.size(), it);
    n_pushed++;
  endtask

  // Sender holds off until every item has gone in and every result is out,
  // then gives the pipe its latency to go quiet.
  task automatic settle();
    do @(posedge clk);
    while (n_accepted != n_pushed || mix_expect_q.size() != 0);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  // Mostly uniform, sometimes a corner value
  function automatic int rand_sample();
    case ($urandom_range(15))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return -1;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin : stim
    logic [31:0]       step;
    logic [31:0]       start;
    logic [MODE_W-1:0] mode;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Dead index must not disturb anything; then all-zero registers
    write_reg(REG_UNUSED, $urandom);
    program_nco(32'h0, 32'h0, MODE_BYPASS);

    // Bypass, first item without a record marker: runs off the reset accumulator
    push_item(32767, -32768, 1'b0);
    push_item(-1, 0, 1'b1);
    settle();

    // Real mix, quarter-turn steps: visits all four quadrants
    program_nco(32'h4000_0000, 32'h0, MODE_REAL);
    push_item(32767, -32768, 1'b1);
    push_item(-32768, 32767, 1'b0);
    push_item(16384, -16384, 1'b0);
    push_item(1, -1, 1'b0);
    settle();

    // Complex mix at -45 degrees: full-scale pairs saturate both ways;
    // a second record start reloads mid-stream
    program_nco(32'hFFFF_FFFF, 32'hE000_0000, MODE_COMPLEX);
    push_item(-32768, -32768, 1'b1);
    push_item(32767, 32767, 1'b0);
    push_item(32767, -32768, 1'b0);
    push_item(0, 0, 1'b1);
    settle();

    // Half-turn step from the top of the phase range
    program_nco(32'h8000_0000, 32'hFFFF_FFFF, MODE_COMPLEX);
    push_item(-32768, 32767, 1'b1);
    push_item(-32768, -32768, 1'b0);
    push_item(12345, -23456, 1'b0);
    settle();

    // Unused mode code passes samples through
    program_nco(32'h0010_0000, 32'h4000_0000, MODE_UNUSED);
    push_item(-32768, 32767, 1'b1);
    push_item(-2, 2, 1'b0);
    push_item(21845, -21846, 1'b0);
    settle();

    // Random records under a range of settings
    for (int b = 0; b < N_BATCH; b++) begin
      case (b)
        0:       step = 32'h0;
        1:       step = 32'hFFFF_FFFF;
        default: step = $urandom >> $urandom_range(31);
      endcase
      case (b)
        2:       start = 32'h0;
        3:       start = 32'hFFFF_FFFF;
        default: start = $urandom;
      endcase
      if (b % 4 == 3)
        mode = (b == 3) ? MODE_UNUSED : MODE_BYPASS;
      else
        mode = (b % 2 == 1) ? MODE_REAL : MODE_COMPLEX;
      // one batch with both sides streaming flat out
      idle_pct = (b == 5) ? 0 : 30;
      program_nco(step, start, mode);
      for (int i = 0; i < BATCH_ITEMS; i++)
        push_item(rand_sample(), rand_sample(),
                  (i == 0) ? (b % 4 != 2) : ($urandom_range(47) == 0));
      settle();
    end

    if (n_err == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
